/* rtl/core/tpsd_pkg.sv */
`default_nettype none

package tpsd_pkg;

    // Width of the store that holds the earlier bytes of the pixel being gathered.
    localparam int MAX_PIXEL_BITS = 24;

    // Depth of the word queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int TOTAL_W = 25;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RLE_ENABLE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_TOTAL     = 2'd2;

    typedef logic [2:0] size_t;

    // Pixel size codes.
    localparam size_t SIZE_1555 = 3'd2;
    localparam size_t SIZE_BGR  = 3'd3;
    localparam size_t SIZE_BGRA = 3'd4;

    // Packet header fields.
    localparam logic [7:0] HDR_RUN_BIT    = 8'h80;
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

    // One fully gathered pixel, handed from the front to the back.
    typedef struct packed {
        logic [MAX_PIXEL_BITS-1:0] gather;
        logic [7:0]                last_byte;
        size_t                     size;
        logic [7:0]                count;
        logic                      image_done;
    } pix_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Sizes below two read as 1555, sizes above four as BGRA.
    function automatic size_t pixel_size(input logic [2:0] bpp);
        size_t s;
        if (bpp <= SIZE_1555) begin
            s = SIZE_1555;
        end else if (bpp == SIZE_BGR) begin
            s = SIZE_BGR;
        end else begin
            s = SIZE_BGRA;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tga_pixel_stream_decoder.sv */
// TGA image body decoder: bytes in, RGBA pixels with a repeat count out.
// The s_ channel takes one word per cycle while s_ready is high, each word one
// byte of the image body that follows the file header. The m_ channel delivers
// one word per decoded pixel: red, green, blue, alpha, a repeat count of 1 to
// 128 and a flag that marks the word completing the pixel total. Header bytes
// of run-length packets, the leading bytes of a pixel and every byte after the
// pixel total produce no word. The three configuration registers (pixel size,
// run-length enable, pixel total) are written through cfg_wr_en, cfg_index and
// cfg_wr_data; the user must write them only while the block is idle, which the
// block does not enforce; every write restarts decoding. Throughput is one byte
// per cycle while the queue is not full, and a pixel takes two, three or four
// bytes for 1555, BGR and BGRA pixels; words held back by a stall can leave on
// consecutive cycles. A pixel word is written into the queue at the edge that
// accepts its last byte and moves into the output register when the back is
// free. The front and back are parted by a two-word queue and the back owns the
// output register: when the receiver stalls, up to two words collect in the
// queue plus one in the output register, and then s_ready falls.
// A synchronous reset (aresetn low) empties the queue, drops m_valid and loads
// the reset configuration: 4-byte pixels, no run-length coding, total zero.
`default_nettype none

module tga_pixel_stream_decoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tpsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tpsd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_data_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_red,
    output logic [7:0]                         m_green,
    output logic [7:0]                         m_blue,
    output logic [7:0]                         m_alpha,
    output logic [7:0]                         m_repeat_count,
    output logic                               m_image_done
);
    import tpsd_pkg::*;

    // Words that the front finished and the back has not yet taken.
    pix_word_t push_word;
    pix_word_t head_word;
    q_status_t q_status;
    logic      q_push;
    logic      q_pop;

    // The front tracks packets, gathers pixel bytes and counts pixels against the total.
    tpsd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_status    (q_status),
        .push        (q_push),
        .push_word   (push_word)
    );

    tpsd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_word (push_word),
        .pop       (q_pop),
        .head_word (head_word),
        .status    (q_status)
    );

    // The back converts the gathered bytes to RGBA and holds the output register.
    tpsd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_word      (head_word),
        .q_status       (q_status),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_alpha        (m_alpha),
        .m_repeat_count (m_repeat_count),
        .m_image_done   (m_image_done)
    );

    // The front never writes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("word pushed into a full queue");

    // The back never takes a word from an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("word popped from an empty queue");

    // Every delivered word covers at least one pixel and at most one full run.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_repeat_count != 8'd0) && (m_repeat_count <= 8'd128))
        else $error("repeat count out of range");

    // A word that fills the queue was pushed while the back could not drain it.
    a_fill_needs_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) ##1 q_status.full |-> $past(m_valid && !m_ready))
        else $error("queue filled while the output was free");

endmodule

`default_nettype wire

/* rtl/core/tpsd_queue.sv */
`default_nettype none

module tpsd_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire tpsd_pkg::pix_word_t push_word,
    input  wire logic               pop,
    output tpsd_pkg::pix_word_t     head_word,
    output tpsd_pkg::q_status_t     status
);
    import tpsd_pkg::*;

    pix_word_t                mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        logic [QUEUE_PTR_W-1:0] n;
        if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + QUEUE_PTR_W'(1);
        end
        return n;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    assign head_word    = mem[rd_ptr_reg];
    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

/* rtl/core/tpsd_front.sv */
`default_nettype none

module tpsd_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tpsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tpsd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_data_byte,
    input  wire tpsd_pkg::q_status_t           q_status,
    output logic                               push,
    output tpsd_pkg::pix_word_t                push_word
);
    import tpsd_pkg::*;

    // Configuration.
    logic [2:0]          bpp_reg;
    logic                rle_reg;
    logic [TOTAL_W-1:0]  total_reg;

    // Decode state.
    logic                      expect_header_reg, expect_header_next;
    logic [7:0]                packet_left_reg, packet_left_next;
    logic                      packet_is_run_reg, packet_is_run_next;
    logic [MAX_PIXEL_BITS-1:0] gather_reg, gather_next;
    logic [1:0]                position_reg, position_next;
    logic [TOTAL_W-1:0]        pixels_done_reg, pixels_done_next;

    logic               accept;
    logic               image_full;
    size_t              size;
    logic [7:0]         count;
    logic [7:0]         count_trim;
    logic [TOTAL_W-1:0] remain;
    logic               restart;

    assign s_ready    = !q_status.full;
    assign accept     = s_valid && s_ready;
    assign size       = pixel_size(bpp_reg);
    assign image_full = (pixels_done_reg >= total_reg);
    assign remain     = total_reg - pixels_done_reg;
    assign restart    = cfg_wr_en && (cfg_index <= REG_PIXEL_TOTAL);

    always_comb begin
        expect_header_next = expect_header_reg;
        packet_left_next   = packet_left_reg;
        packet_is_run_next = packet_is_run_reg;
        gather_next        = gather_reg;
        position_next      = position_reg;
        pixels_done_next   = pixels_done_reg;
        push               = 1'b0;
        count              = 8'd1;
        count_trim         = 8'd1;

        if (accept && !image_full) begin
            if (rle_reg && expect_header_reg) begin
                packet_is_run_next = (s_data_byte & HDR_RUN_BIT) != 8'h00;
                packet_left_next   = (s_data_byte & HDR_COUNT_MASK) + 8'd1;
                expect_header_next = 1'b0;
                position_next      = '0;
                gather_next        = '0;
            end else if (({1'b0, position_reg} + 3'd1) < size) begin
                gather_next   = gather_reg
                              | (MAX_PIXEL_BITS'(s_data_byte) << {position_reg, 3'b000});
                position_next = position_reg + 2'd1;
            end else begin
                push          = 1'b1;
                gather_next   = '0;
                position_next = '0;
                if (rle_reg) begin
                    if (packet_is_run_reg) begin
                        count            = packet_left_reg;
                        packet_left_next = 8'd0;
                    end else if (packet_left_reg != 8'd0) begin
                        packet_left_next = packet_left_reg - 8'd1;
                    end
                    if (packet_left_next == 8'd0) begin
                        expect_header_next = 1'b1;
                    end
                end
                if (count == 8'd0) begin
                    count = 8'd1;
                end
                count_trim = (TOTAL_W'(count) > remain) ? remain[7:0] : count;
                pixels_done_next = pixels_done_reg + TOTAL_W'(count_trim);
            end
        end
    end

    always_comb begin
        push_word.gather     = gather_reg;
        push_word.last_byte  = s_data_byte;
        push_word.size       = size;
        push_word.count      = count_trim;
        push_word.image_done = (pixels_done_next == total_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg   <= SIZE_BGRA;
            rle_reg   <= 1'b0;
            total_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BYTES_PER_PIXEL: bpp_reg   <= cfg_wr_data[2:0];
                REG_RLE_ENABLE:      rle_reg   <= cfg_wr_data[0];
                REG_PIXEL_TOTAL:     total_reg <= cfg_wr_data[TOTAL_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg <= 1'b0;
            packet_left_reg   <= '0;
            packet_is_run_reg <= 1'b0;
            gather_reg        <= '0;
            position_reg      <= '0;
            pixels_done_reg   <= '0;
        end else if (restart) begin
            expect_header_reg <= (cfg_index == REG_RLE_ENABLE) ? cfg_wr_data[0] : rle_reg;
            packet_left_reg   <= '0;
            packet_is_run_reg <= 1'b0;
            gather_reg        <= '0;
            position_reg      <= '0;
            pixels_done_reg   <= '0;
        end else begin
            expect_header_reg <= expect_header_next;
            packet_left_reg   <= packet_left_next;
            packet_is_run_reg <= packet_is_run_next;
            gather_reg        <= gather_next;
            position_reg      <= position_next;
            pixels_done_reg   <= pixels_done_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tpsd_back.sv */
`default_nettype none

module tpsd_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire tpsd_pkg::pix_word_t head_word,
    input  wire tpsd_pkg::q_status_t q_status,
    output logic                     pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [7:0]               m_red,
    output logic [7:0]               m_green,
    output logic [7:0]               m_blue,
    output logic [7:0]               m_alpha,
    output logic [7:0]               m_repeat_count,
    output logic                     m_image_done
);
    import tpsd_pkg::*;

    logic        m_valid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg, count_reg;
    logic        done_reg;

    logic [31:0] g32;
    logic [7:0]  b0, b1, b2, bl;
    logic [7:0]  r, g, bc, a;

    assign g32 = 32'(head_word.gather);
    assign b0  = g32[7:0];
    assign b1  = g32[15:8];
    assign b2  = g32[23:16];
    assign bl  = head_word.last_byte;

    always_comb begin
        unique case (head_word.size)
            SIZE_BGRA: begin
                bc = b0; g = b1; r = b2; a = bl;
            end
            SIZE_BGR: begin
                bc = b0; g = b1; r = bl; a = ALPHA_OPAQUE;
            end
            default: begin
                // 1555: five bits per channel, top bit of the high byte is alpha.
                r  = (bl & 8'h7c) << 1;
                g  = ((bl & 8'h03) << 6) | ((b0 & 8'he0) >> 2);
                bc = (b0 & 8'h1f) << 3;
                a  = bl & 8'h80;
            end
        endcase
    end

    assign pop = !q_status.empty && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            red_reg   <= r;
            green_reg <= g;
            blue_reg  <= bc;
            alpha_reg <= a;
            count_reg <= head_word.count;
            done_reg  <= head_word.image_done;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_alpha        = alpha_reg;
    assign m_repeat_count = count_reg;
    assign m_image_done   = done_reg;

endmodule

`default_nettype wire
